// File: rtl/assert_macros.svh
// Assertion macros shared by the biquad filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("biquad assertion failed");
`define BQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("biquad assertion failed");
`else
`define BQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/biq_pkg.sv
// Types, constants and microprogram of the multichannel biquad filter.
`default_nettype none
package biq_pkg;

    localparam int CHANNELS       = 8;
    localparam int CH_BITS        = 3;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int STATE_BITS     = 32;
    localparam int PROD_BITS      = COEF_BITS + STATE_BITS;
    localparam int ACC_BITS       = 64;
    localparam int TDATA_BITS     = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int STEP_BITS      = 4;
    localparam int MAX_STEP       = 9;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE   = COEF_BITS'(1 << COEF_FRAC_BITS);
    localparam logic signed [COEF_BITS-1:0] B0_RESET   = COEF_BITS'(1 << COEF_FRAC_BITS);
    localparam logic signed [ACC_BITS-1:0]  ROUND_HALF = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0]  STATE_MAX  = (ACC_BITS'(1) <<< (STATE_BITS - 1)) - 1;
    localparam logic signed [ACC_BITS-1:0]  STATE_MIN  = -(ACC_BITS'(1) <<< (STATE_BITS - 1));
    localparam logic signed [STATE_BITS-1:0] SAMPLE_MAX =
        (STATE_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [STATE_BITS-1:0] SAMPLE_MIN =
        -(STATE_BITS'(1) <<< (SAMPLE_BITS - 1));

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_B0     = 3'd0,
        CFG_B1     = 3'd1,
        CFG_B2     = 3'd2,
        CFG_A1     = 3'd3,
        CFG_A2     = 3'd4,
        CFG_STRUCT = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_DF1  = 2'd0,
        ST_DF2  = 2'd1,
        ST_TDF1 = 2'd2,
        ST_TDF2 = 2'd3
    } struct_t;

    typedef enum logic [2:0] {
        CS_B0, CS_B1, CS_B2, CS_A1, CS_A2, CS_ONE
    } coef_sel_t;

    typedef enum logic [3:0] {
        OP_X, OP_X1, OP_X2, OP_Y1, OP_Y2, OP_W1, OP_W2, OP_TW, OP_TY
    } opnd_sel_t;

    typedef enum logic [3:0] {
        DS_NONE, DS_X1, DS_X2, DS_Y1, DS_Y2, DS_W1, DS_W2, DS_TW, DS_TY
    } dest_sel_t;

    typedef struct packed {
        coef_sel_t coef;
        opnd_sel_t opnd;
        dest_sel_t dest;
        logic      last;
        logic      done;
    } uop_t;

    typedef struct packed {
        logic start;
        logic issue;
        uop_t uop;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

    function automatic uop_t mk(coef_sel_t c, opnd_sel_t o, dest_sel_t d,
                                logic last, logic done);
        uop_t u;
        u.coef = c;
        u.opnd = o;
        u.dest = d;
        u.last = last;
        u.done = done;
        return u;
    endfunction

    // One multiply-accumulate term per step; a term marked last closes a node.
    function automatic uop_t biq_uop(struct_t st, logic [STEP_BITS-1:0] step);
        uop_t u;
        u = mk(CS_ONE, OP_X, DS_NONE, 1'b1, 1'b1);
        case (st)
            ST_DF1: begin
                case (step)
                    4'd0:    u = mk(CS_B0,  OP_X,  DS_NONE, 1'b0, 1'b0);
                    4'd1:    u = mk(CS_B1,  OP_X1, DS_NONE, 1'b0, 1'b0);
                    4'd2:    u = mk(CS_B2,  OP_X2, DS_NONE, 1'b0, 1'b0);
                    4'd3:    u = mk(CS_A1,  OP_Y1, DS_NONE, 1'b0, 1'b0);
                    4'd4:    u = mk(CS_A2,  OP_Y2, DS_TY,   1'b1, 1'b0);
                    4'd5:    u = mk(CS_ONE, OP_X1, DS_X2,   1'b1, 1'b0);
                    4'd6:    u = mk(CS_ONE, OP_Y1, DS_Y2,   1'b1, 1'b0);
                    4'd7:    u = mk(CS_ONE, OP_X,  DS_X1,   1'b1, 1'b0);
                    4'd8:    u = mk(CS_ONE, OP_TY, DS_Y1,   1'b1, 1'b1);
                    default: u = mk(CS_ONE, OP_X,  DS_NONE, 1'b1, 1'b1);
                endcase
            end
            ST_DF2: begin
                case (step)
                    4'd0:    u = mk(CS_ONE, OP_X,  DS_NONE, 1'b0, 1'b0);
                    4'd1:    u = mk(CS_A1,  OP_W1, DS_NONE, 1'b0, 1'b0);
                    4'd2:    u = mk(CS_A2,  OP_W2, DS_TW,   1'b1, 1'b0);
                    4'd3:    u = mk(CS_B0,  OP_TW, DS_NONE, 1'b0, 1'b0);
                    4'd4:    u = mk(CS_B1,  OP_W1, DS_NONE, 1'b0, 1'b0);
                    4'd5:    u = mk(CS_B2,  OP_W2, DS_TY,   1'b1, 1'b0);
                    4'd6:    u = mk(CS_ONE, OP_W1, DS_W2,   1'b1, 1'b0);
                    4'd7:    u = mk(CS_ONE, OP_TW, DS_W1,   1'b1, 1'b1);
                    default: u = mk(CS_ONE, OP_X,  DS_NONE, 1'b1, 1'b1);
                endcase
            end
            ST_TDF1: begin
                case (step)
                    4'd0:    u = mk(CS_ONE, OP_X,  DS_NONE, 1'b0, 1'b0);
                    4'd1:    u = mk(CS_ONE, OP_W2, DS_TW,   1'b1, 1'b0);
                    4'd2:    u = mk(CS_B0,  OP_TW, DS_NONE, 1'b0, 1'b0);
                    4'd3:    u = mk(CS_ONE, OP_X2, DS_TY,   1'b1, 1'b0);
                    4'd4:    u = mk(CS_B1,  OP_TW, DS_NONE, 1'b0, 1'b0);
                    4'd5:    u = mk(CS_ONE, OP_X1, DS_X2,   1'b1, 1'b0);
                    4'd6:    u = mk(CS_A1,  OP_TW, DS_NONE, 1'b0, 1'b0);
                    4'd7:    u = mk(CS_ONE, OP_W1, DS_W2,   1'b1, 1'b0);
                    4'd8:    u = mk(CS_B2,  OP_TW, DS_X1,   1'b1, 1'b0);
                    4'd9:    u = mk(CS_A2,  OP_TW, DS_W1,   1'b1, 1'b1);
                    default: u = mk(CS_ONE, OP_X,  DS_NONE, 1'b1, 1'b1);
                endcase
            end
            ST_TDF2: begin
                case (step)
                    4'd0:    u = mk(CS_B0,  OP_X,  DS_NONE, 1'b0, 1'b0);
                    4'd1:    u = mk(CS_ONE, OP_X2, DS_TY,   1'b1, 1'b0);
                    4'd2:    u = mk(CS_B1,  OP_X,  DS_NONE, 1'b0, 1'b0);
                    4'd3:    u = mk(CS_ONE, OP_X1, DS_NONE, 1'b0, 1'b0);
                    4'd4:    u = mk(CS_A1,  OP_TY, DS_X2,   1'b1, 1'b0);
                    4'd5:    u = mk(CS_B2,  OP_X,  DS_NONE, 1'b0, 1'b0);
                    4'd6:    u = mk(CS_A2,  OP_TY, DS_X1,   1'b1, 1'b1);
                    default: u = mk(CS_ONE, OP_X,  DS_NONE, 1'b1, 1'b1);
                endcase
            end
            default: u = mk(CS_ONE, OP_X, DS_NONE, 1'b1, 1'b1);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: rtl/biq_ctrl.sv
// Sequencer that walks the per-structure microprogram for one sample.
`default_nettype none
`include "assert_macros.svh"
module biq_ctrl
    import biq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire struct_t   structure,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_ISSUE   = 5'b00010,
        S_DRAIN1  = 5'b00100,
        S_DRAIN2  = 5'b01000,
        S_DELIVER = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   done_reg, done_next;
    uop_t                   uop;

    assign uop      = biq_uop(structure, step_reg);
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        done_next    = done_reg;
        cmd.start    = 1'b0;
        cmd.issue    = 1'b0;
        cmd.uop      = uop;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    done_next  = 1'b0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                cmd.issue = 1'b1;
                step_next = step_reg + STEP_BITS'(1);
                if (uop.last) begin
                    done_next  = uop.done;
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2: state_next = done_reg ? S_DELIVER : S_ISSUE;
            S_DELIVER: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    `BQ_ASSERT_IMP(a_step_bound, aclk, aresetn, state_reg == S_ISSUE,
                   step_reg <= STEP_BITS'(MAX_STEP))
    `BQ_ASSERT_NXT(a_issue_last_drains, aclk, aresetn, cmd.issue && uop.last,
                   state_reg == S_DRAIN1)

endmodule
`default_nettype wire

// File: rtl/biq_dp.sv
// Shared multiply-accumulate datapath with per-channel delay registers.
`default_nettype none
`include "assert_macros.svh"
module biq_dp
    import biq_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ctrl_cmd_t                     cmd,
    input  wire logic                          clear,
    input  wire logic [TDATA_BITS-1:0]         s_tdata,
    input  wire logic signed [COEF_BITS-1:0]   coef_b0,
    input  wire logic signed [COEF_BITS-1:0]   coef_b1,
    input  wire logic signed [COEF_BITS-1:0]   coef_b2,
    input  wire logic signed [COEF_BITS-1:0]   coef_a1,
    input  wire logic signed [COEF_BITS-1:0]   coef_a2,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [TDATA_BITS-1:0]              m_tdata,
    output dp_stat_t                           stat
);

    logic signed [STATE_BITS-1:0] x1_reg [CHANNELS];
    logic signed [STATE_BITS-1:0] x2_reg [CHANNELS];
    logic signed [STATE_BITS-1:0] y1_reg [CHANNELS];
    logic signed [STATE_BITS-1:0] y2_reg [CHANNELS];
    logic signed [STATE_BITS-1:0] w1_reg [CHANNELS];
    logic signed [STATE_BITS-1:0] w2_reg [CHANNELS];

    logic [CH_BITS-1:0]            ch_reg;
    logic signed [STATE_BITS-1:0]  x_reg, tw_reg, ty_reg;
    logic                          first_reg;

    logic signed [PROD_BITS-1:0]   prod_reg;
    logic                          p_valid_reg, p_first_reg, p_last_reg;
    dest_sel_t                     p_dest_reg;

    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic                          a_last_reg;
    dest_sel_t                     a_dest_reg;

    logic                          m_tvalid_reg;
    logic [CH_BITS-1:0]            ch_out_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic signed [COEF_BITS-1:0]   coef_v;
    logic signed [STATE_BITS-1:0]  opnd_v;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [ACC_BITS-1:0]    rnd_v, shr_v;
    logic signed [STATE_BITS-1:0]  node_v, y_sat;

    always_comb begin
        case (cmd.uop.coef)
            CS_B0:   coef_v = coef_b0;
            CS_B1:   coef_v = coef_b1;
            CS_B2:   coef_v = coef_b2;
            CS_A1:   coef_v = coef_a1;
            CS_A2:   coef_v = coef_a2;
            default: coef_v = COEF_ONE;
        endcase
        case (cmd.uop.opnd)
            OP_X:    opnd_v = x_reg;
            OP_X1:   opnd_v = x1_reg[ch_reg];
            OP_X2:   opnd_v = x2_reg[ch_reg];
            OP_Y1:   opnd_v = y1_reg[ch_reg];
            OP_Y2:   opnd_v = y2_reg[ch_reg];
            OP_W1:   opnd_v = w1_reg[ch_reg];
            OP_W2:   opnd_v = w2_reg[ch_reg];
            OP_TW:   opnd_v = tw_reg;
            default: opnd_v = ty_reg;
        endcase
    end

    assign prod_next = PROD_BITS'(coef_v) * PROD_BITS'(opnd_v);
    assign acc_next  = (p_first_reg ? '0 : acc_reg) + ACC_BITS'(prod_reg);

    // Round half up, drop the fraction, clamp to the state width.
    always_comb begin
        rnd_v = acc_reg + ROUND_HALF;
        shr_v = rnd_v >>> COEF_FRAC_BITS;
        if (shr_v > STATE_MAX) begin
            node_v = STATE_MAX[STATE_BITS-1:0];
        end else if (shr_v < STATE_MIN) begin
            node_v = STATE_MIN[STATE_BITS-1:0];
        end else begin
            node_v = shr_v[STATE_BITS-1:0];
        end
        if (ty_reg > SAMPLE_MAX) begin
            y_sat = SAMPLE_MAX;
        end else if (ty_reg < SAMPLE_MIN) begin
            y_sat = SAMPLE_MIN;
        end else begin
            y_sat = ty_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg  <= 1'b0;
            a_last_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            first_reg    <= 1'b1;
        end else begin
            p_valid_reg <= cmd.issue;
            a_last_reg  <= p_valid_reg && p_last_reg;
            if (cmd.start) begin
                first_reg <= 1'b1;
            end else if (cmd.issue) begin
                first_reg <= cmd.uop.last;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ch_reg <= s_tdata[CH_BITS-1:0];
            x_reg  <= STATE_BITS'($signed(s_tdata[CH_BITS +: SAMPLE_BITS]));
        end
        if (cmd.issue) begin
            prod_reg    <= prod_next;
            p_first_reg <= first_reg;
            p_last_reg  <= cmd.uop.last;
            p_dest_reg  <= cmd.uop.dest;
        end
        if (p_valid_reg) begin
            acc_reg    <= acc_next;
            a_dest_reg <= p_dest_reg;
        end
        if (a_last_reg && a_dest_reg == DS_TW) begin
            tw_reg <= node_v;
        end
        if (a_last_reg && a_dest_reg == DS_TY) begin
            ty_reg <= node_v;
        end
        if (cmd.load_out) begin
            ch_out_reg     <= ch_reg;
            sample_out_reg <= y_sat[SAMPLE_BITS-1:0];
        end
    end

    // Delay state: reset and structure change clear every channel at once.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
                w1_reg[i] <= '0;
                w2_reg[i] <= '0;
            end
        end else if (a_last_reg) begin
            case (a_dest_reg)
                DS_X1:   x1_reg[ch_reg] <= node_v;
                DS_X2:   x2_reg[ch_reg] <= node_v;
                DS_Y1:   y1_reg[ch_reg] <= node_v;
                DS_Y2:   y2_reg[ch_reg] <= node_v;
                DS_W1:   w1_reg[ch_reg] <= node_v;
                DS_W2:   w2_reg[ch_reg] <= node_v;
                default: ;
            endcase
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = {{(TDATA_BITS - SAMPLE_BITS - CH_BITS){1'b0}},
                            sample_out_reg, ch_out_reg};
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    `BQ_ASSERT_IMP(a_write_after_issue, aclk, aresetn, a_last_reg,
                   $past(cmd.issue && cmd.uop.last, 2))
    `BQ_ASSERT_IMP(a_load_when_free, aclk, aresetn, cmd.load_out,
                   !m_tvalid_reg || m_tready)
    `BQ_ASSERT_IMP(a_start_when_drained, aclk, aresetn, cmd.start,
                   !p_valid_reg && !a_last_reg)

endmodule
`default_nettype wire

// File: rtl/multichannel_biquad_filter_core.sv
// Top level of the multichannel biquad filter: config registers and core wiring.
`default_nettype none
// Second-order IIR section shared by eight interleaved audio channels.
// Input stream (s_): one transfer carries a channel number and a 24-bit sample.
// Output stream (m_): one transfer per input, same channel, filtered sample.
// Coefficients b0,b1,b2,a1,a2 (Q3.20, a1/a2 negated) and the structure select
// are written through cfg_we/cfg_index/cfg_wdata while the block is idle.
// Writing a structure different from the current one clears all delay state.
// Each sample runs as a microprogram on one shared 24x32 multiplier: one term
// per cycle, then per node the drain states S_DRAIN1 and S_DRAIN2 for
// accumulate and round/saturate. The next input is taken only once the
// current result has moved into the output register, so no new sample is
// accepted while one is in progress.
// A stalled receiver holds the result in the output register; the block
// finishes the following sample and waits until that register frees up.
// Reset (aresetn, synchronous, active low) restores default coefficients
// (b0 = 1.0, others 0), selects transposed direct form II and clears all delays.
module multichannel_biquad_filter_core
    import biq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [TDATA_BITS-1:0]    s_tdata,   // [2:0] channel_index, [26:3] sample_in
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [TDATA_BITS-1:0]         m_tdata,   // [2:0] channel_out, [26:3] sample_out
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic signed [COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    struct_t                     structure_reg;
    logic                        clear;
    ctrl_cmd_t                   cmd;
    dp_stat_t                    stat;

    // Clear delays only when the structure actually changes.
    assign clear = cfg_we && (cfg_index == CFG_STRUCT)
                   && (struct_t'(cfg_wdata[1:0]) != structure_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg        <= B0_RESET;
            b1_reg        <= '0;
            b2_reg        <= '0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            structure_reg <= ST_TDF2;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_B0:     b0_reg        <= cfg_wdata;
                CFG_B1:     b1_reg        <= cfg_wdata;
                CFG_B2:     b2_reg        <= cfg_wdata;
                CFG_A1:     a1_reg        <= cfg_wdata;
                CFG_A2:     a2_reg        <= cfg_wdata;
                CFG_STRUCT: structure_reg <= struct_t'(cfg_wdata[1:0]);
                default:    ;   // drop writes beyond the register list
            endcase
        end
    end

    biq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .structure (structure_reg),
        .stat      (stat),
        .cmd       (cmd)
    );

    biq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .clear    (clear),
        .s_tdata  (s_tdata),
        .coef_b0  (b0_reg),
        .coef_b1  (b1_reg),
        .coef_b2  (b2_reg),
        .coef_a1  (a1_reg),
        .coef_a2  (a2_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .stat     (stat)
    );

endmodule
`default_nettype wire
